@@ src/stl_pkg.sv @@
// Shared types, character codes and event kinds for the script token lexer.
// Used by stl_step, stl_run_buf and script_token_lexer_unit; no dependencies.
package stl_pkg;

    localparam int STL_MAX_TOKEN_LEN = 256;
    localparam int STL_RUN_MAX       = 3;

    localparam logic [7:0]  CH_NL     = 8'h0A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_LPAREN = 8'h28;
    localparam logic [7:0]  CH_RPAREN = 8'h29;
    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_SEMI   = 8'h3B;
    localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;

    typedef enum logic [4:0] {
        M_SEEK      = 5'b00001,
        M_PLAIN     = 5'b00010,
        M_QUOTED    = 5'b00100,
        M_LINE_CMT  = 5'b01000,
        M_BLOCK_CMT = 5'b10000
    } t_mode;

    typedef enum logic [2:0] {
        EV_BYTE  = 3'd0,
        EV_END   = 3'd1,
        EV_EOL   = 3'd2,
        EV_LONG  = 3'd3,
        EV_XLINE = 3'd4
    } t_ev_kind;

    typedef struct packed {
        t_mode       mode;
        logic        slash;
        logic        star;
        logic        paren;
        logic        cerr;
        logic [23:0] line;
    } t_scan;

    typedef struct packed {
        logic [7:0] chr;
        t_ev_kind   kind;
    } t_event;

    typedef struct packed {
        logic [1:0]            cnt;
        logic [23:0]           line;
        t_event [STL_RUN_MAX-1:0] ev;
    } t_run;

endpackage

@@ src/stl_step.sv @@
// Next-state and event logic for one text byte of the script token lexer.
// Purely combinational; depends on stl_pkg.
module stl_step
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = STL_MAX_TOKEN_LEN,
    localparam int LW = $clog2(MAX_TOKEN_LEN)
) (
    input  t_scan         i_scan,
    input  logic [LW-1:0] i_tok_len,
    input  logic [7:0]    i_byte,
    input  logic          i_fin,
    input  logic          i_cross_line,
    output t_scan         o_scan,
    output logic [LW-1:0] o_tok_len,
    output t_run          o_run
);

    function automatic t_run push(t_run r, t_ev_kind k, logic [7:0] c);
        t_event e;
        e.kind = k;
        e.chr  = c;
        if (r.cnt < 2'(STL_RUN_MAX)) begin
            r.ev[r.cnt] = e;
            r.cnt       = r.cnt + 2'd1;
        end
        return r;
    endfunction

    t_scan         nxt;
    logic [LW-1:0] len;
    t_run          run;
    logic          is_sep;
    logic          is_nl;
    logic          go_plain;
    logic          go_tok;
    logic          go_seek;
    logic [7:0]    closer;

    always_comb begin
        nxt      = i_scan;
        len      = i_tok_len;
        run      = '0;
        run.line = i_scan.line;
        go_plain = 1'b0;
        go_tok   = 1'b0;
        go_seek  = 1'b0;
        is_nl    = (i_byte == CH_NL);
        is_sep   = (i_byte <= CH_SPACE) || (i_byte == CH_SEMI) || (i_byte == CH_COMMA);
        closer   = i_scan.paren ? CH_RPAREN : CH_QUOTE;

        if (i_scan.mode == M_SEEK && i_scan.slash) begin
            nxt.slash = 1'b0;
            if (i_byte == CH_SLASH) begin
                nxt.mode = M_LINE_CMT;
            end else if (i_byte == CH_STAR) begin
                nxt.mode = M_BLOCK_CMT;
                nxt.star = 1'b0;
                nxt.cerr = 1'b0;
            end else begin
                run      = push(run, EV_BYTE, CH_SLASH);
                len      = LW'(1);
                nxt.mode = M_PLAIN;
                go_plain = 1'b1;
            end
        end else begin
            unique case (i_scan.mode)
                M_SEEK: begin
                    go_seek = 1'b1;
                end
                M_PLAIN: begin
                    go_plain = 1'b1;
                end
                M_QUOTED: begin
                    if (i_byte == closer) begin
                        run      = push(run, EV_END, 8'd0);
                        nxt.mode = M_SEEK;
                        len      = '0;
                    end else begin
                        go_tok = 1'b1;
                    end
                end
                M_LINE_CMT: begin
                    if (is_nl) begin
                        if (!i_cross_line) begin
                            run = push(run, EV_EOL, 8'd0);
                        end
                        if (nxt.line != LINE_MAX) begin
                            nxt.line = nxt.line + 24'd1;
                        end
                        nxt.mode = M_SEEK;
                    end
                end
                M_BLOCK_CMT: begin
                    if (i_scan.star && i_byte == CH_SLASH) begin
                        if (i_scan.cerr) begin
                            run = push(run, EV_XLINE, 8'd0);
                        end
                        nxt.mode = M_SEEK;
                        nxt.star = 1'b0;
                        nxt.cerr = 1'b0;
                    end else begin
                        if (is_nl) begin
                            if (!i_cross_line) begin
                                nxt.cerr = 1'b1;
                            end
                            if (nxt.line != LINE_MAX) begin
                                nxt.line = nxt.line + 24'd1;
                            end
                        end
                        nxt.star = (i_byte == CH_STAR);
                    end
                end
                default: begin
                    nxt.mode  = M_SEEK;
                    nxt.slash = 1'b0;
                    go_seek   = 1'b1;
                end
            endcase
        end

        if (go_plain) begin
            if (is_sep) begin
                run      = push(run, EV_END, 8'd0);
                nxt.mode = M_SEEK;
                len      = '0;
                go_seek  = 1'b1;
            end else begin
                go_tok = 1'b1;
            end
        end

        if (go_tok) begin
            if (len >= LW'(MAX_TOKEN_LEN - 1)) begin
                run      = push(run, EV_LONG, 8'd0);
                nxt.mode = M_SEEK;
                len      = '0;
                go_seek  = 1'b1;
            end else begin
                run = push(run, EV_BYTE, i_byte);
                len = len + LW'(1);
            end
        end

        if (go_seek) begin
            if (is_nl) begin
                if (!i_cross_line) begin
                    run = push(run, EV_EOL, 8'd0);
                end
                if (nxt.line != LINE_MAX) begin
                    nxt.line = nxt.line + 24'd1;
                end
            end else if (is_sep) begin
                nxt.mode = M_SEEK;
            end else if (i_byte == CH_SLASH) begin
                nxt.slash = 1'b1;
            end else if (i_byte == CH_QUOTE || i_byte == CH_LPAREN) begin
                nxt.mode  = M_QUOTED;
                nxt.paren = (i_byte == CH_LPAREN);
                len       = '0;
            end else begin
                run      = push(run, EV_BYTE, i_byte);
                len      = LW'(1);
                nxt.mode = M_PLAIN;
            end
        end

        if (i_fin) begin
            if (nxt.mode == M_SEEK && nxt.slash) begin
                run = push(run, EV_BYTE, CH_SLASH);
                run = push(run, EV_END, 8'd0);
            end else if (nxt.mode == M_PLAIN || nxt.mode == M_QUOTED) begin
                run = push(run, EV_END, 8'd0);
            end
            nxt.mode  = M_SEEK;
            nxt.slash = 1'b0;
            nxt.star  = 1'b0;
            nxt.paren = 1'b0;
            nxt.cerr  = 1'b0;
            len       = '0;
        end
    end

    assign o_scan    = nxt;
    assign o_tok_len = len;
    assign o_run     = run;

endmodule

@@ src/stl_run_buf.sv @@
// Result register for the script token lexer: holds the events of one text byte
// and hands them out one item per cycle while tready is high. Depends on stl_pkg.
module stl_run_buf
    import stl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_run        i_run,
    output logic        o_room,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,   // token_char[7:0], line_number[31:8]
    output logic [2:0]  o_tuser,   // event_kind[2:0]
    output logic        o_tlast    // last_of_run
);

    logic [1:0]               r_cnt;
    logic [23:0]              r_line;
    t_event [STL_RUN_MAX-1:0] r_ev;
    logic                     pop;

    assign o_tvalid = (r_cnt != 2'd0);
    assign pop      = o_tvalid && i_tready;
    assign o_room   = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_tready);
    assign o_tlast  = (r_cnt == 2'd1);
    assign o_tdata  = {r_line, r_ev[0].chr};
    assign o_tuser  = r_ev[0].kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_run.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev   <= i_run.ev;
            r_line <= i_run.line;
        end else if (pop) begin
            r_ev <= {t_event'('0), r_ev[STL_RUN_MAX-1:1]};
        end
    end

    // A new run must never overwrite events that have not been delivered.
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_room)
        else $error("run loaded over undelivered events");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_cnt == $past(i_run.cnt))
        else $error("run count not taken over");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && r_ev[0].kind != EV_BYTE) |-> r_ev[0].chr == 8'd0)
        else $error("nonzero character on a non-byte event");

endmodule

@@ src/script_token_lexer_unit.sv @@
// Top level of the script token lexer: input register, scan state and result buffer.
// Depends on stl_pkg, stl_step and stl_run_buf.
//
// Usage:
// Text enters on the slave stream one byte per item: tdata carries the byte and
// tlast marks the final byte of a buffer, which closes any open token.
// Events leave on the master stream, one item each: tuser carries the event kind,
// tdata the token byte and line number, and tlast marks the final event caused by
// one text byte. A byte may cause no event or up to three.
// The cross-line register is written through i_cfg_we / i_cfg_data; the user
// must write it only while idle, as the block does not enforce this. An accepted
// byte passes the input register, then the result buffer. One byte is taken per
// cycle while each byte causes at most one event and the receiver keeps tready high;
// a byte with several events holds the input until the result buffer, which sends
// one event per cycle, is sending its last. Bytes with no event pass during a stall.
// When the receiver stalls, undelivered events stay in the result buffer and the
// input register holds the next byte; o_s_tready drops until there is room.
// Reset clears the scan state and line count and sets cross-line to one.
module script_token_lexer_unit
    import stl_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = STL_MAX_TOKEN_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // text_byte[7:0]
    input  logic        i_s_tlast,   // final_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // token_char[7:0], line_number[31:8]
    output logic [2:0]  o_m_tuser,   // event_kind[2:0]
    output logic        o_m_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    localparam int LW = $clog2(MAX_TOKEN_LEN);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_fin;
    logic          r_cross_line;
    t_scan         r_scan;
    logic [LW-1:0] r_tok_len;
    t_scan         n_scan;
    logic [LW-1:0] n_tok_len;
    t_run          run;
    logic          room;
    logic          consume;
    logic          load;

    assign consume    = r_in_valid && (run.cnt == 2'd0 || room);
    assign load       = consume && (run.cnt != 2'd0);
    assign o_s_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_fin  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross_line <= 1'b1;
        end else if (i_cfg_we) begin
            r_cross_line <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '{mode: M_SEEK, slash: 1'b0, star: 1'b0, paren: 1'b0,
                           cerr: 1'b0, line: 24'd0};
            r_tok_len <= '0;
        end else if (consume) begin
            r_scan    <= n_scan;
            r_tok_len <= n_tok_len;
        end
    end

    stl_step #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_step (
        .i_scan      (r_scan),
        .i_tok_len   (r_tok_len),
        .i_byte      (r_in_byte),
        .i_fin       (r_in_fin),
        .i_cross_line(r_cross_line),
        .o_scan      (n_scan),
        .o_tok_len   (n_tok_len),
        .o_run       (run)
    );

    stl_run_buf u_run_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_run   (run),
        .o_room  (room),
        .o_tvalid(o_m_tvalid),
        .i_tready(i_m_tready),
        .o_tdata (o_m_tdata),
        .o_tuser (o_m_tuser),
        .o_tlast (o_m_tlast)
    );

    // A pending slash only exists while seeking a token.
    a_slash_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan.slash |-> r_scan.mode == M_SEEK)
        else $error("slash pending outside seek mode");

    // Token length is only kept inside a token.
    a_len_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan.mode == M_SEEK || r_scan.mode == M_LINE_CMT
            || r_scan.mode == M_BLOCK_CMT) |-> r_tok_len == '0)
        else $error("token length left over outside a token");

    // An offered event stays offered until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("event withdrawn before it was taken");

endmodule
